// ===== sv/lcp_pkg.sv =====
`timescale 1ns / 1ps

package lcp_pkg;

    // link modes
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_READY  = 2'd1,
        MODE_ACTIVE = 2'd2
    } t_mode;

    // command and data byte codes
    localparam logic [7:0] CMD_FLIP       = 8'h80;
    localparam logic [7:0] CMD_BRIGHT     = 8'hC0;
    localparam logic [7:0] CMD_LOCKED_MIN = 8'hD0;
    localparam logic [7:0] CMD_SYNC       = 8'hE0;
    localparam logic [7:0] CMD_SELECT     = 8'hE1;
    localparam logic [7:0] CMD_RESET_MIN  = 8'hF0;
    localparam logic [7:0] SYNC_FIRST     = 8'hF0;
    localparam logic [7:0] SYNC_SECOND    = 8'hF1;
    localparam logic [7:0] SYNC_THIRD     = 8'hF2;
    localparam logic [7:0] SEL_ALL_BYTE   = 8'hFF;

    localparam logic [2:0] BOARD_ALL      = 3'd4;
    localparam int unsigned NUM_BOARDS    = 4;
    localparam int unsigned DEF_PAGE_COUNT = 4;
    localparam int unsigned QUEUE_DEPTH   = 4;

    // job handed from the front end to the back end
    typedef struct packed {
        logic       flip;
        logic       broadcast;
        logic [1:0] board;
        logic [6:0] offset;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] display_page;
        logic [7:0] write_page;
        logic       refresh;
    } t_job;

endpackage

// ===== sv/lcp_front.sv =====
`timescale 1ns / 1ps

module lcp_front #(
    parameter int unsigned PAGE_COUNT = lcp_pkg::DEF_PAGE_COUNT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rx_valid,
    output logic          o_rx_stall,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_q_full,
    output logic          o_push,
    output lcp_pkg::t_job o_job
);
    import lcp_pkg::*;

    localparam logic [8:0]  PageDiv  = 9'(PAGE_COUNT);
    localparam int unsigned Recip    = (65536 + PAGE_COUNT - 1) / PAGE_COUNT;
    localparam logic [16:0] RecipMul = 17'(Recip);

    logic [1:0] r_pos, n_pos;
    logic [7:0] r_cmd, n_cmd;
    logic [7:0] r_d1, n_d1;
    logic [7:0] r_d2, n_d2;
    t_mode      r_mode, n_mode;
    logic [2:0] r_board, n_board;
    logic       r_differ, n_differ;

    logic       accept;
    logic       job_valid;
    logic [7:0] disp_mod;
    logic [7:0] wr_mod;

    // byte modulo page count: reciprocal multiply for the quotient, then back-subtract
    function automatic logic [7:0] page_rem(input logic [7:0] value);
        logic [23:0] prod;
        logic [7:0]  quot;
        logic [16:0] back;
        prod = {16'd0, value} * {7'd0, RecipMul};
        quot = 8'(prod >> 16);
        back = {9'd0, quot} * {8'd0, PageDiv};
        return value - 8'(back);
    endfunction

    // hold off only on a frame end while the queue is full
    assign o_rx_stall = i_q_full && (r_pos == 2'd3);
    assign accept     = i_rx_valid && !o_rx_stall;

    assign disp_mod = page_rem(r_d2);
    assign wr_mod   = page_rem(i_rx_byte);

    // framing and command decode
    always_comb begin
        n_pos     = r_pos;
        n_cmd     = r_cmd;
        n_d1      = r_d1;
        n_d2      = r_d2;
        n_mode    = r_mode;
        n_board   = r_board;
        n_differ  = r_differ;
        job_valid = 1'b0;
        o_job     = '0;
        o_job.offset = r_cmd[6:0];
        o_job.red    = r_d1;
        o_job.green  = r_d2;
        o_job.blue   = i_rx_byte;
        o_job.board  = r_board[1:0];
        if (accept) begin
            case (r_pos)
                2'd0: begin
                    if (i_rx_byte >= CMD_RESET_MIN) begin
                        n_mode = MODE_IDLE;
                    end else begin
                        n_cmd = i_rx_byte;
                        n_pos = 2'd1;
                    end
                end
                2'd1: begin
                    n_d1  = i_rx_byte;
                    n_pos = 2'd2;
                end
                2'd2: begin
                    n_d2  = i_rx_byte;
                    n_pos = 2'd3;
                end
                default: begin
                    n_pos = 2'd0;
                    if (r_cmd < CMD_LOCKED_MIN && r_mode != MODE_ACTIVE) begin
                        // frame dropped outside the active mode
                    end else if (r_cmd == CMD_SYNC) begin
                        if (r_d1 == SYNC_FIRST && r_d2 == SYNC_SECOND &&
                            i_rx_byte == SYNC_THIRD) begin
                            n_mode = MODE_READY;
                        end else begin
                            n_mode = MODE_IDLE;
                        end
                    end else if (r_mode == MODE_IDLE) begin
                        // idle link drops the frame
                    end else if (r_cmd < CMD_FLIP) begin
                        job_valid       = 1'b1;
                        o_job.broadcast = (r_board == BOARD_ALL);
                        o_job.refresh   = !r_differ;
                    end else if (r_cmd == CMD_FLIP) begin
                        job_valid          = 1'b1;
                        o_job.flip         = 1'b1;
                        o_job.display_page = disp_mod;
                        o_job.write_page   = wr_mod;
                        o_job.refresh      = 1'b1;
                        n_differ           = (disp_mod != wr_mod);
                    end else if (r_cmd == CMD_BRIGHT) begin
                        // brightness has no effect
                    end else if (r_cmd == CMD_SELECT) begin
                        if (r_d1 == SEL_ALL_BYTE) begin
                            n_mode  = MODE_ACTIVE;
                            n_board = BOARD_ALL;
                        end else if (r_d1 < 8'(NUM_BOARDS)) begin
                            n_mode  = MODE_ACTIVE;
                            n_board = r_d1[2:0];
                        end else begin
                            n_mode = MODE_READY;
                        end
                    end else begin
                        n_mode = MODE_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_push = job_valid;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 2'd0;
            r_cmd    <= '0;
            r_d1     <= '0;
            r_d2     <= '0;
            r_mode   <= MODE_IDLE;
            r_board  <= '0;
            r_differ <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_cmd    <= n_cmd;
            r_d1     <= n_d1;
            r_d2     <= n_d2;
            r_mode   <= n_mode;
            r_board  <= n_board;
            r_differ <= n_differ;
        end
    end

endmodule

// ===== sv/lcp_queue.sv =====
`timescale 1ns / 1ps

module lcp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lcp_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output lcp_pkg::t_job o_head
);
    import lcp_pkg::*;

    localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

    t_job              r_slot [QUEUE_DEPTH];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [PtrW:0]     r_count;

    assign o_full  = (r_count == (PtrW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/lcp_back.sv =====
`timescale 1ns / 1ps

module lcp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  lcp_pkg::t_job i_head,
    output logic          o_pop,
    output logic          o_res_valid,
    input  logic          i_res_stall,
    output logic          o_kind,
    output logic [2:0]    o_pos_x,
    output logic [2:0]    o_pos_y,
    output logic [2:0]    o_pos_z,
    output logic [7:0]    o_red,
    output logic [7:0]    o_green,
    output logic [7:0]    o_blue,
    output logic [7:0]    o_display_page,
    output logic [7:0]    o_write_page,
    output logic          o_refresh,
    output logic          o_last
);
    import lcp_pkg::*;

    logic       r_valid;
    logic [1:0] r_sub;
    logic       load;
    logic       final_beat;
    logic [1:0] board;

    logic       r_kind;
    logic [2:0] r_x, r_y, r_z;
    logic [7:0] r_red, r_green, r_blue, r_disp, r_wr;
    logic       r_refresh, r_last;

    // output register loads from a non-empty queue when empty or draining
    assign load       = (!r_valid || !i_res_stall) && !i_q_empty;
    assign final_beat = !i_head.broadcast || (r_sub == 2'(NUM_BOARDS - 1));
    assign o_pop      = load && final_beat;
    assign board      = i_head.broadcast ? r_sub : i_head.board;

    // control: valid flag and broadcast board counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_valid <= 1'b0;
            end
            if (load && i_head.broadcast) begin
                r_sub <= final_beat ? 2'd0 : r_sub + 1'b1;
            end
        end
    end

    // result payload, coordinates mapped from board and offset; coordinates and colour cleared for a flip
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind    <= i_head.flip;
            r_refresh <= i_head.refresh;
            r_last    <= final_beat;
            r_disp    <= i_head.flip ? i_head.display_page : 8'd0;
            r_wr      <= i_head.flip ? i_head.write_page : 8'd0;
            if (i_head.flip) begin
                r_x     <= '0;
                r_y     <= '0;
                r_z     <= '0;
                r_red   <= '0;
                r_green <= '0;
                r_blue  <= '0;
            end else begin
                r_x     <= ~i_head.offset[2:0];
                r_y     <= ~{board, ~i_head.offset[3]};
                r_z     <= {i_head.offset[6:5], ~i_head.offset[4]};
                r_red   <= i_head.red;
                r_green <= i_head.green;
                r_blue  <= i_head.blue;
            end
        end
    end

    assign o_res_valid    = r_valid;
    assign o_kind         = r_kind;
    assign o_pos_x        = r_x;
    assign o_pos_y        = r_y;
    assign o_pos_z        = r_z;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_display_page = r_disp;
    assign o_write_page   = r_wr;
    assign o_refresh      = r_refresh;
    assign o_last         = r_last;

endmodule

// ===== sv/led_cube_command_parser.sv =====
`timescale 1ns / 1ps

// channel   valid         stall         payload
// rx        i_rx_valid    o_rx_stall    i_rx_byte
// result    o_res_valid   i_res_stall   o_kind .. o_last
//
// one byte per cycle while o_rx_stall is low; a result is registered in a job queue slot, then in the output register
// a broadcast pixel drains as four beats, one per cycle while i_res_stall is low, from the job queue
// rx stalls only on a frame-ending byte while the four-entry job queue is full
// synchronous active-low reset clears link mode, framing, queue and output valid
module led_cube_command_parser #(
    parameter int unsigned PAGE_COUNT = lcp_pkg::DEF_PAGE_COUNT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic       o_kind,
    output logic [2:0] o_pos_x,
    output logic [2:0] o_pos_y,
    output logic [2:0] o_pos_z,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue,
    output logic [7:0] o_display_page,
    output logic [7:0] o_write_page,
    output logic       o_refresh,
    output logic       o_last
);
    import lcp_pkg::*;

    logic push, pop, q_full, q_empty;
    t_job job_in, job_head;

    // framing and classification
    lcp_front #(.PAGE_COUNT(PAGE_COUNT)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_stall (o_rx_stall),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (job_in)
    );

    // job queue between the two sides
    lcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (job_head)
    );

    // result generation
    lcp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_head         (job_head),
        .o_pop          (pop),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .o_kind         (o_kind),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_pos_z        (o_pos_z),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_display_page (o_display_page),
        .o_write_page   (o_write_page),
        .o_refresh      (o_refresh),
        .o_last         (o_last)
    );

endmodule
